FILE: sv/assert_macros.svh
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: sv/lsr_pkg.sv
package lsr_pkg;

    // Coordinate width of every input and output point field
    localparam int COORD_BITS = 6;
    // Signed difference width and error accumulator width
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int ACC_BITS   = COORD_BITS + 2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;
    } sts_t;

endpackage

FILE: sv/line_segment_rasterizer.sv
// Channel   Ports                                        Direction
// s_        s_start_x s_start_y s_end_x s_end_y          in, one beat per segment
// m_        m_point_x m_point_y m_has_point m_last       out, one beat per pixel
//
// A segment with major-axis span n gives n beats: the setup registers load first,
// then one beat per pixel from the shared step unit.
// A segment whose start equals its end gives one beat with has_point low.
// Reset returns the controller to idle with s_ready high.
// m_ready low holds the current pixel; s_ready stays low until the last beat leaves.
`include "assert_macros.svh"

module line_segment_rasterizer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lsr_pkg::COORD_BITS-1:0] s_start_x,
    input  logic [lsr_pkg::COORD_BITS-1:0] s_start_y,
    input  logic [lsr_pkg::COORD_BITS-1:0] s_end_x,
    input  logic [lsr_pkg::COORD_BITS-1:0] s_end_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lsr_pkg::COORD_BITS-1:0] m_point_x,
    output logic [lsr_pkg::COORD_BITS-1:0] m_point_y,
    output logic                           m_has_point,
    output logic                           m_last
);
    import lsr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence beats
    lsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Walk the segment
    lsr_datapath u_datapath (
        .aclk      (aclk),
        .start_x   (s_start_x),
        .start_y   (s_start_y),
        .end_x     (s_end_x),
        .end_y     (s_end_y),
        .cmd       (cmd),
        .sts       (sts),
        .point_x   (m_point_x),
        .point_y   (m_point_y),
        .has_point (m_has_point)
    );

    assign m_last = sts.last;

    // Input and output sides never open at once
    `ASSERT_IMPLIES(a_ready_excl, aclk, aresetn, s_ready, !m_valid)
    // A degenerate beat closes its segment
    `ASSERT_IMPLIES(a_degen_last, aclk, aresetn, m_valid && !m_has_point, m_last)
    // After the closing beat the block takes a new segment
    `ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_last, s_ready)
    // A non-final beat is followed by another pixel
    `ASSERT_NEXT(a_more_pixels, aclk, aresetn, m_valid && m_ready && !m_last,
                 m_valid && m_has_point)

endmodule

FILE: sv/lsr_ctrl.sv
module lsr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output lsr_pkg::cmd_t cmd,
    input  lsr_pkg::sts_t sts
);
    import lsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (sts.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/lsr_datapath.sv
module lsr_datapath (
    input  logic                           aclk,
    input  logic [lsr_pkg::COORD_BITS-1:0] start_x,
    input  logic [lsr_pkg::COORD_BITS-1:0] start_y,
    input  logic [lsr_pkg::COORD_BITS-1:0] end_x,
    input  logic [lsr_pkg::COORD_BITS-1:0] end_y,
    input  lsr_pkg::cmd_t                  cmd,
    output lsr_pkg::sts_t                  sts,
    output logic [lsr_pkg::COORD_BITS-1:0] point_x,
    output logic [lsr_pkg::COORD_BITS-1:0] point_y,
    output logic                           has_point
);
    import lsr_pkg::*;

    // Segment setup, worked out from the input beat
    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic signed [DIFF_BITS-1:0] dx_neg;
    logic signed [DIFF_BITS-1:0] dy_neg;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;
    logic                        x_major;
    logic                        degen;
    logic signed [DIFF_BITS-1:0] dmaj;
    logic signed [DIFF_BITS-1:0] dmin;
    logic signed [DIFF_BITS-1:0] dmin_norm;
    logic        [COORD_BITS-1:0] span;

    // Walk state
    logic [COORD_BITS-1:0]       maj_reg,   maj_next;
    logic [COORD_BITS-1:0]       min_reg,   min_next;
    logic [COORD_BITS-1:0]       rem_reg,   rem_next;
    logic [COORD_BITS-1:0]       err_reg,   err_next;
    logic [COORD_BITS-1:0]       n_reg,     n_next;
    logic signed [DIFF_BITS-1:0] dmin_reg,  dmin_next;
    logic                        neg_reg,   neg_next;
    logic                        xmaj_reg,  xmaj_next;
    logic                        degen_reg, degen_next;

    logic signed [ACC_BITS-1:0]  acc;
    logic signed [ACC_BITS-1:0]  n_ext;

    // Differences, magnitudes and axis choice; ties pick y
    always_comb begin
        dx      = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        dy      = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
        dx_neg  = -dx;
        dy_neg  = -dy;
        adx     = dx[DIFF_BITS-1] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady     = dy[DIFF_BITS-1] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        x_major = adx > ady;
        degen   = (adx == '0) && (ady == '0);
        dmaj    = x_major ? dx : dy;
        dmin    = x_major ? dy : dx;
        span    = x_major ? adx : ady;
        // Negate the minor delta when the major delta is negative
        dmin_norm = dmaj[DIFF_BITS-1] ? -dmin : dmin;
    end

    // Error accumulator: remainder of dmin*k over n, one correction per step
    always_comb begin
        acc   = $signed({2'b00, err_reg})
              + $signed({{(ACC_BITS-DIFF_BITS){dmin_reg[DIFF_BITS-1]}}, dmin_reg});
        n_ext = $signed({2'b00, n_reg});
    end

    // Load a new segment or advance one pixel
    always_comb begin
        maj_next   = maj_reg;
        min_next   = min_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        n_next     = n_reg;
        dmin_next  = dmin_reg;
        neg_next   = neg_reg;
        xmaj_next  = xmaj_reg;
        degen_next = degen_reg;
        if (cmd.load) begin
            degen_next = degen;
            xmaj_next  = x_major;
            neg_next   = dmaj[DIFF_BITS-1];
            n_next     = span;
            dmin_next  = dmin_norm;
            err_next   = '0;
            rem_next   = span - COORD_BITS'(1);
            if (degen) begin
                maj_next = '0;
                min_next = '0;
            end else begin
                maj_next = x_major ? start_x : start_y;
                min_next = x_major ? start_y : start_x;
            end
        end else if (cmd.advance) begin
            rem_next = rem_reg - COORD_BITS'(1);
            maj_next = neg_reg ? maj_reg - COORD_BITS'(1) : maj_reg + COORD_BITS'(1);
            if (!dmin_reg[DIFF_BITS-1] && (acc >= n_ext)) begin
                err_next = COORD_BITS'(acc - n_ext);
                min_next = min_reg + COORD_BITS'(1);
            end else if (acc < 0) begin
                err_next = COORD_BITS'(acc + n_ext);
                min_next = min_reg - COORD_BITS'(1);
            end else begin
                err_next = COORD_BITS'(acc);
            end
        end
    end

    // Hold walk state
    always_ff @(posedge aclk) begin
        maj_reg   <= maj_next;
        min_reg   <= min_next;
        rem_reg   <= rem_next;
        err_reg   <= err_next;
        n_reg     <= n_next;
        dmin_reg  <= dmin_next;
        neg_reg   <= neg_next;
        xmaj_reg  <= xmaj_next;
        degen_reg <= degen_next;
    end

    // Present current pixel
    assign point_x   = xmaj_reg ? maj_reg : min_reg;
    assign point_y   = xmaj_reg ? min_reg : maj_reg;
    assign has_point = !degen_reg;
    assign sts.last  = degen_reg || (rem_reg == '0);

endmodule
